>>> hdl/bmrld_pkg.sv
// ----------------------------------------------------------------------------
// bmrld_pkg
// Shared types and constants of the bitmap run-length decoder: header layout,
// result kinds, status codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrld_pkg;

    // header layout
    localparam int unsigned HDR_WORDS = 10;
    localparam int unsigned HDR_IDX_W = 4;
    localparam logic [31:0] HDR_LEN   = 32'h0000_0028;

    // header word positions
    localparam logic [HDR_IDX_W-1:0] W_LENGTH = 4'd0;
    localparam logic [HDR_IDX_W-1:0] W_OFFSET = 4'd1;
    localparam logic [HDR_IDX_W-1:0] W_COLS   = 4'd2;
    localparam logic [HDR_IDX_W-1:0] W_ROWS   = 4'd3;
    localparam logic [HDR_IDX_W-1:0] W_WIDTH  = 4'd4;
    localparam logic [HDR_IDX_W-1:0] W_HEIGHT = 4'd5;
    localparam logic [HDR_IDX_W-1:0] W_MODE   = 4'd6;
    localparam logic [HDR_IDX_W-1:0] W_RSVD0  = 4'd7;
    localparam logic [HDR_IDX_W-1:0] W_RSVD1  = 4'd8;
    localparam logic [HDR_IDX_W-1:0] W_ENC    = 4'd9;

    // encoding word values
    localparam logic [31:0] ENC_CODE_RAW = 32'h0000_0000;
    localparam logic [31:0] ENC_CODE_RLE = 32'h0000_0001;

    // run-length markers
    localparam logic [7:0] REP_LIMIT = 8'h80;
    localparam logic [8:0] LIT_BASE  = 9'h100;
    localparam logic [7:0] WORD_BYTES = 8'd4;

    // result kinds
    localparam logic [1:0] KIND_DESC  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_MODE = 3'd1;
    localparam logic [2:0] STAT_RSVD     = 3'd2;
    localparam logic [2:0] STAT_BAD_ENC  = 3'd3;
    localparam logic [2:0] STAT_BACK_OFF = 3'd4;

    // error flag bits
    localparam int unsigned FLG_MODE = 0;
    localparam int unsigned FLG_RSVD = 1;
    localparam int unsigned FLG_ENC  = 2;
    localparam int unsigned FLG_OFF  = 3;

    typedef struct packed {
        logic take;   // latch the accepted input byte
        logic upd;    // store byte, advance position, step the run state
        logic eval;   // resolve phase changes and plan the results
        logic emit;   // load the next planned result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic pending;    // a result is still planned
        logic last_item;  // the next result to load is the last one
        logic load_ok;    // output register is free or being drained
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/bmrld_ctrl.sv
// ----------------------------------------------------------------------------
// bmrld_ctrl
// Sequencer of the decoder: accept one byte, update, evaluate, then drain the
// planned results into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrld_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bmrld_pkg::dp_stat_t   stat,
    output bmrld_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_EVAL = 4'b0100,
        S_EMIT = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = (state_reg == S_EMIT) && stat.pending && stat.load_ok;

    always_comb
    begin
        cmd.take = in_valid && in_ready;
        cmd.upd  = (state_reg == S_UPD);
        cmd.eval = (state_reg == S_EVAL);
        cmd.emit = fire;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // leave once nothing is planned or the final result goes out
                if (!stat.pending || (fire && stat.last_item))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bmrld_dpath.sv
// ----------------------------------------------------------------------------
// bmrld_dpath
// Datapath of the decoder: header store, record position, run state, error
// flags, result plan and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrld_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bmrld_pkg::ctrl_cmd_t  cmd,
    output bmrld_pkg::dp_stat_t        stat,
    input  wire logic                  cfg_wr_en,
    input  wire logic [31:0]           cfg_wr_data,
    input  wire logic [7:0]            in_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 kind,
    output logic [31:0]                columns,
    output logic [31:0]                rows,
    output logic [31:0]                pix_width,
    output logic [31:0]                pix_height,
    output logic [31:0]                pixels,
    output logic [2:0]                 pixel_count,
    output logic [2:0]                 status,
    output logic                       last
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SKIP    = 2'd1,
        PH_DATA    = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RM_MARKER  = 2'd0,
        RM_REPEAT  = 2'd1,
        RM_LITERAL = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        ENC_RAW = 2'd0,
        ENC_RLE = 2'd1,
        ENC_BAD = 2'd2
    } enc_t;

    function automatic logic [31:0] lane_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] status_code(input logic [3:0] f);
        logic [2:0] s;
        if (f[bmrld_pkg::FLG_MODE])
            s = bmrld_pkg::STAT_BAD_MODE;
        else if (f[bmrld_pkg::FLG_RSVD])
            s = bmrld_pkg::STAT_RSVD;
        else if (f[bmrld_pkg::FLG_ENC])
            s = bmrld_pkg::STAT_BAD_ENC;
        else if (f[bmrld_pkg::FLG_OFF])
            s = bmrld_pkg::STAT_BACK_OFF;
        else
            s = bmrld_pkg::STAT_OK;
        return s;
    endfunction

    // state
    logic [31:0] mode_reg;
    logic [7:0]  byte_reg;
    logic [31:0] hdr_reg  [bmrld_pkg::HDR_WORDS];
    logic [31:0] hdr_next [bmrld_pkg::HDR_WORDS];
    phase_t      phase_reg,    phase_next;
    logic [31:0] pos_reg,      pos_next;
    enc_t        enc_reg,      enc_next;
    logic [7:0]  run_left_reg, run_left_next;
    run_mode_t   run_mode_reg, run_mode_next;
    logic [3:0]  flags_reg,    flags_next;

    // result plan
    logic        desc_pend_reg, desc_pend_next;
    logic        end_pend_reg,  end_pend_next;
    logic [7:0]  pix_left_reg,  pix_left_next;
    logic [7:0]  pix_byte_reg,  pix_byte_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] columns_reg, rows_reg, width_reg, height_reg, pixels_reg;
    logic [2:0]  count_reg, status_reg;
    logic        last_reg;

    // evaluation helpers
    logic [31:0] eff_off;
    logic [31:0] rec_len;
    logic        hdr_done;
    logic        load_ok;
    logic [2:0]  pix_take;
    logic [bmrld_pkg::HDR_IDX_W-1:0] wr_idx;

    assign wr_idx   = pos_reg[5:2];
    assign rec_len  = hdr_reg[bmrld_pkg::W_LENGTH];
    assign eff_off  = (hdr_reg[bmrld_pkg::W_OFFSET] < bmrld_pkg::HDR_LEN)
                      ? bmrld_pkg::HDR_LEN : hdr_reg[bmrld_pkg::W_OFFSET];
    assign hdr_done = (phase_reg == PH_HEADER) && (pos_reg >= bmrld_pkg::HDR_LEN);
    assign load_ok  = !out_valid_reg || out_ready;
    assign pix_take = (pix_left_reg >= bmrld_pkg::WORD_BYTES)
                      ? 3'd4 : pix_left_reg[2:0];

    always_comb
    begin
        stat.load_ok = load_ok;
        stat.pending = desc_pend_reg || end_pend_reg || (pix_left_reg != 8'd0);
        if (desc_pend_reg)
            stat.last_item = !end_pend_reg && (pix_left_reg == 8'd0);
        else if (pix_left_reg != 8'd0)
            stat.last_item = !end_pend_reg && (pix_left_reg <= bmrld_pkg::WORD_BYTES);
        else
            stat.last_item = 1'b1;
    end

    always_comb
    begin
        phase_t ph_a;
        phase_t ph_b;
        enc_t   enc_a;
        logic [3:0] flags_a;

        hdr_next       = hdr_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        enc_next       = enc_reg;
        run_left_next  = run_left_reg;
        run_mode_next  = run_mode_reg;
        flags_next     = flags_reg;
        desc_pend_next = desc_pend_reg;
        end_pend_next  = end_pend_reg;
        pix_left_next  = pix_left_reg;
        pix_byte_next  = pix_byte_reg;
        ph_a           = phase_reg;
        ph_b           = phase_reg;
        enc_a          = enc_reg;
        flags_a        = flags_reg;

        if (cmd.upd)
        begin
            pos_next      = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
            pix_left_next = 8'd0;
            pix_byte_next = byte_reg;
            if (phase_reg == PH_HEADER)
            begin
                if ({28'd0, wr_idx} < bmrld_pkg::HDR_WORDS)
                begin
                    hdr_next[wr_idx][{pos_reg[1:0], 3'b000} +: 8] = byte_reg;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                if (enc_reg == ENC_RAW)
                begin
                    pix_left_next = 8'd1;
                end
                else
                begin
                    case (run_mode_reg)
                        RM_MARKER:
                        begin
                            if (byte_reg < bmrld_pkg::REP_LIMIT)
                            begin
                                run_left_next = byte_reg + 8'd1;
                                run_mode_next = RM_REPEAT;
                            end
                            else
                            begin
                                run_left_next = 8'(bmrld_pkg::LIT_BASE - {1'b0, byte_reg});
                                run_mode_next = RM_LITERAL;
                            end
                        end
                        RM_REPEAT:
                        begin
                            // whole run goes out as packed words
                            pix_left_next = run_left_reg;
                            run_left_next = 8'd0;
                            run_mode_next = RM_MARKER;
                        end
                        default:
                        begin
                            pix_left_next = 8'd1;
                            run_left_next = run_left_reg - 8'd1;
                            if (run_left_reg == 8'd1)
                            begin
                                run_mode_next = RM_MARKER;
                            end
                        end
                    endcase
                end
            end
        end

        if (cmd.eval)
        begin
            if (hdr_done)
            begin
                if (hdr_reg[bmrld_pkg::W_MODE] != mode_reg)
                    flags_a[bmrld_pkg::FLG_MODE] = 1'b1;
                if ((hdr_reg[bmrld_pkg::W_RSVD0] != 32'd0) ||
                    (hdr_reg[bmrld_pkg::W_RSVD1] != 32'd0))
                    flags_a[bmrld_pkg::FLG_RSVD] = 1'b1;
                if (hdr_reg[bmrld_pkg::W_OFFSET] < bmrld_pkg::HDR_LEN)
                    flags_a[bmrld_pkg::FLG_OFF] = 1'b1;
                if (hdr_reg[bmrld_pkg::W_ENC] == bmrld_pkg::ENC_CODE_RAW)
                    enc_a = ENC_RAW;
                else if (hdr_reg[bmrld_pkg::W_ENC] == bmrld_pkg::ENC_CODE_RLE)
                    enc_a = ENC_RLE;
                else
                begin
                    enc_a = ENC_BAD;
                    flags_a[bmrld_pkg::FLG_ENC] = 1'b1;
                end
                ph_a = (enc_a == ENC_BAD) ? PH_DISCARD : PH_SKIP;
            end
            ph_b = ph_a;
            if ((ph_a == PH_SKIP) && (pos_reg >= eff_off))
            begin
                ph_b = PH_DATA;
            end
            phase_next     = ph_b;
            enc_next       = enc_a;
            flags_next     = flags_a;
            desc_pend_next = hdr_done;
            end_pend_next  = ((ph_b == PH_DATA) && (run_mode_reg == RM_MARKER) &&
                              (pos_reg >= rec_len)) ||
                             ((ph_b == PH_DISCARD) && (pos_reg >= rec_len));
        end

        if (cmd.emit)
        begin
            if (desc_pend_reg)
            begin
                desc_pend_next = 1'b0;
            end
            else if (pix_left_reg != 8'd0)
            begin
                pix_left_next = pix_left_reg - {5'd0, pix_take};
            end
            else
            begin
                // end result goes out: close the record
                end_pend_next = 1'b0;
                phase_next    = PH_HEADER;
                pos_next      = 32'd0;
                enc_next      = ENC_RAW;
                run_left_next = 8'd0;
                run_mode_next = RM_MARKER;
                flags_next    = 4'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 32'd0;
            phase_reg     <= PH_HEADER;
            pos_reg       <= 32'd0;
            enc_reg       <= ENC_RAW;
            run_left_reg  <= 8'd0;
            run_mode_reg  <= RM_MARKER;
            flags_reg     <= 4'd0;
            desc_pend_reg <= 1'b0;
            end_pend_reg  <= 1'b0;
            pix_left_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            enc_reg       <= enc_next;
            run_left_reg  <= run_left_next;
            run_mode_reg  <= run_mode_next;
            flags_reg     <= flags_next;
            desc_pend_reg <= desc_pend_next;
            end_pend_reg  <= end_pend_next;
            pix_left_reg  <= pix_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg      <= hdr_next;
        pix_byte_reg <= pix_byte_next;
        if (cmd.take)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            status_reg  <= status_code(flags_reg);
            columns_reg <= 32'd0;
            rows_reg    <= 32'd0;
            width_reg   <= 32'd0;
            height_reg  <= 32'd0;
            pixels_reg  <= 32'd0;
            count_reg   <= 3'd0;
            if (desc_pend_reg)
            begin
                kind_reg    <= bmrld_pkg::KIND_DESC;
                columns_reg <= hdr_reg[bmrld_pkg::W_COLS];
                rows_reg    <= hdr_reg[bmrld_pkg::W_ROWS];
                width_reg   <= hdr_reg[bmrld_pkg::W_WIDTH];
                height_reg  <= hdr_reg[bmrld_pkg::W_HEIGHT];
                last_reg    <= !end_pend_reg && (pix_left_reg == 8'd0);
            end
            else if (pix_left_reg != 8'd0)
            begin
                kind_reg   <= bmrld_pkg::KIND_PIXEL;
                pixels_reg <= {4{pix_byte_reg}} & lane_mask(pix_take);
                count_reg  <= pix_take;
                last_reg   <= !end_pend_reg && (pix_left_reg <= bmrld_pkg::WORD_BYTES);
            end
            else
            begin
                kind_reg <= bmrld_pkg::KIND_END;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign columns     = columns_reg;
    assign rows        = rows_reg;
    assign pix_width   = width_reg;
    assign pix_height  = height_reg;
    assign pixels      = pixels_reg;
    assign pixel_count = count_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> hdl/bitmap_run_length_decoder.sv
// ----------------------------------------------------------------------------
// bitmap_run_length_decoder
// Parses a 40-byte bitmap record header, then emits a descriptor, uncompressed
// or run-length decoded pixel words and an end result per record.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | in_byte
//  output   | out_valid / out_ready | kind columns rows pix_width pix_height
//           |                       | pixels pixel_count status last
//  config   | cfg_wr_en             | cfg_wr_data (expected display mode)
//
//  A byte passes through the sequencer states accept, update and evaluate,
//  then a drain state that loads each planned result into the output
//  register and that is passed through even when there is no result; a
//  repeat run of 128 bytes gives 32 pixel words.
//  The next input byte is taken while the final result still waits.
//  Reset clears the record state and the output valid; the header store
//  needs no clearing. An output stall holds the sequencer in its drain state.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_run_length_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      columns,
    output logic [31:0]      rows,
    output logic [31:0]      pix_width,
    output logic [31:0]      pix_height,
    output logic [31:0]      pixels,
    output logic [2:0]       pixel_count,
    output logic [2:0]       status,
    output logic             last
);

    bmrld_pkg::ctrl_cmd_t cmd;
    bmrld_pkg::dp_stat_t  stat;

    bmrld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmrld_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .columns     (columns),
        .rows        (rows),
        .pix_width   (pix_width),
        .pix_height  (pix_height),
        .pixels      (pixels),
        .pixel_count (pixel_count),
        .status      (status),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> hdl/bmrld_checker.sv
// ----------------------------------------------------------------------------
// bmrld_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrld_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [31:0] pixels,
    input wire logic [2:0]  pixel_count,
    input wire logic        last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pixels) &&
                                    $stable(pixel_count) && $stable(last))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == bmrld_pkg::KIND_DESC) || (kind == bmrld_pkg::KIND_PIXEL) ||
                      (kind == bmrld_pkg::KIND_END))
        else $error("illegal result kind");

    a_pix_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == bmrld_pkg::KIND_PIXEL) |->
            (pixel_count != 3'd0) && (pixel_count <= 3'd4))
        else $error("pixel word with bad byte count");

    a_no_pix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != bmrld_pkg::KIND_PIXEL) |->
            (pixels == 32'd0) && (pixel_count == 3'd0))
        else $error("pixel bytes on non-pixel result");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == bmrld_pkg::KIND_END) |-> last)
        else $error("end result not marked last");

endmodule

bind bitmap_run_length_decoder bmrld_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .pixels      (pixels),
    .pixel_count (pixel_count),
    .last        (last)
);

`default_nettype wire

>>> bench/bitmap_run_length_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_run_length_decoder_test
// Streams bitmap records through the decoder byte by byte and checks every
// result against a cycle-free predictor of header parsing, skipping, raw
// copy, run-length expansion and record close, under random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module bitmap_run_length_decoder_test;

    localparam int unsigned CLK_PERIOD  = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned PHASE_BYTES = 40;

    typedef enum logic [2:0] {PARSE_HEADER, PARSE_SKIP, PARSE_DATA, PARSE_DISCARD} parse_t;
    typedef enum logic [1:0] {RUN_MARKER, RUN_REPEAT, RUN_LITERAL} run_t;
    typedef enum logic [1:0] {SEL_RAW, SEL_RLE, SEL_BAD} enc_sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] columns;
        logic [31:0] rows;
        logic [31:0] pix_width;
        logic [31:0] pix_height;
        logic [31:0] pixels;
        logic [2:0]  pixel_count;
        logic [2:0]  status;
        logic        last;
    } pix_result_t;

    class record_scoreboard;
        logic [31:0] mode_reg;
        parse_t      parse;
        logic [31:0] pos;
        logic [31:0] rec_len;
        logic [31:0] data_start;
        enc_sel_t    enc;
        logic [7:0]  run_left;
        run_t        run;
        logic [3:0]  flags;
        logic [31:0] hdr [bmrld_pkg::HDR_WORDS];
        pix_result_t due [$];
        int          fails;
        int          bytes_in;
        int          descs;
        int          words;
        int          ends;

        function new();
            mode_reg = '0;
            fails    = 0;
            bytes_in = 0;
            descs    = 0;
            words    = 0;
            ends     = 0;
            clear_record();
        endfunction

        function void clear_record();
            parse      = PARSE_HEADER;
            pos        = '0;
            rec_len    = '0;
            data_start = '0;
            enc        = SEL_RAW;
            run_left   = '0;
            run        = RUN_MARKER;
            flags      = '0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function logic [2:0] status_code();
            if (flags[bmrld_pkg::FLG_MODE]) return bmrld_pkg::STAT_BAD_MODE;
            if (flags[bmrld_pkg::FLG_RSVD]) return bmrld_pkg::STAT_RSVD;
            if (flags[bmrld_pkg::FLG_ENC])  return bmrld_pkg::STAT_BAD_ENC;
            if (flags[bmrld_pkg::FLG_OFF])  return bmrld_pkg::STAT_BACK_OFF;
            return bmrld_pkg::STAT_OK;
        endfunction

        function void add_result(logic [1:0] k, logic [31:0] pix, logic [2:0] cnt);
            pix_result_t r;
            logic        is_desc;
            logic        is_pix;
            is_desc       = (k == bmrld_pkg::KIND_DESC);
            is_pix        = (k == bmrld_pkg::KIND_PIXEL);
            r.kind        = k;
            r.columns     = is_desc ? hdr[bmrld_pkg::W_COLS] : '0;
            r.rows        = is_desc ? hdr[bmrld_pkg::W_ROWS] : '0;
            r.pix_width   = is_desc ? hdr[bmrld_pkg::W_WIDTH] : '0;
            r.pix_height  = is_desc ? hdr[bmrld_pkg::W_HEIGHT] : '0;
            r.pixels      = is_pix ? pix : '0;
            r.pixel_count = is_pix ? cnt : '0;
            r.status      = status_code();
            r.last        = 1'b0;
            due = {due, r};
            if (is_desc)
                descs++;
            else if (is_pix)
                words++;
            else
                ends++;
        endfunction

        function void advance();
            if (pos != 32'hFFFF_FFFF)
                pos = pos + 1;
        endfunction

        // work out every result one accepted byte causes
        function void note_byte(logic [7:0] b);
            int          n_start;
            int          i;
            logic [31:0] off;
            logic [7:0]  left;
            logic [2:0]  chunk;
            logic [31:0] w;
            logic [8:0]  lit;
            n_start = due.size();
            bytes_in++;
            case (parse)
                PARSE_HEADER:
                begin
                    hdr[pos[5:2]] = hdr[pos[5:2]] | ({24'd0, b} << {pos[1:0], 3'b000});
                    advance();
                    if (pos >= bmrld_pkg::HDR_LEN)
                    begin
                        off     = hdr[bmrld_pkg::W_OFFSET];
                        rec_len = hdr[bmrld_pkg::W_LENGTH];
                        if (hdr[bmrld_pkg::W_MODE] != mode_reg)
                            flags[bmrld_pkg::FLG_MODE] = 1'b1;
                        if (hdr[bmrld_pkg::W_RSVD0] != 0 || hdr[bmrld_pkg::W_RSVD1] != 0)
                            flags[bmrld_pkg::FLG_RSVD] = 1'b1;
                        // backward offset: flag and start data right after the header
                        if (off < bmrld_pkg::HDR_LEN)
                        begin
                            flags[bmrld_pkg::FLG_OFF] = 1'b1;
                            off = bmrld_pkg::HDR_LEN;
                        end
                        data_start = off;
                        if (hdr[bmrld_pkg::W_ENC] == bmrld_pkg::ENC_CODE_RAW)
                            enc = SEL_RAW;
                        else if (hdr[bmrld_pkg::W_ENC] == bmrld_pkg::ENC_CODE_RLE)
                            enc = SEL_RLE;
                        else
                        begin
                            enc = SEL_BAD;
                            flags[bmrld_pkg::FLG_ENC] = 1'b1;
                        end
                        add_result(bmrld_pkg::KIND_DESC, '0, '0);
                        parse = (enc == SEL_BAD) ? PARSE_DISCARD : PARSE_SKIP;
                    end
                end
                PARSE_SKIP, PARSE_DISCARD:
                    advance();
                default:
                begin
                    if (enc == SEL_RAW)
                        add_result(bmrld_pkg::KIND_PIXEL, {24'd0, b}, 3'd1);
                    else
                    begin
                        case (run)
                            RUN_MARKER:
                            begin
                                if (b < bmrld_pkg::REP_LIMIT)
                                begin
                                    run_left = b + 8'd1;
                                    run      = RUN_REPEAT;
                                end
                                else
                                begin
                                    lit      = bmrld_pkg::LIT_BASE - {1'b0, b};
                                    run_left = lit[7:0];
                                    run      = RUN_LITERAL;
                                end
                            end
                            RUN_REPEAT:
                            begin
                                // expand the repeat into words of up to four bytes
                                left = run_left;
                                while (left != 0)
                                begin
                                    chunk = (left < bmrld_pkg::WORD_BYTES)
                                            ? left[2:0] : bmrld_pkg::WORD_BYTES[2:0];
                                    w = '0;
                                    for (i = 0; i < chunk; i++)
                                        w[8*i +: 8] = b;
                                    add_result(bmrld_pkg::KIND_PIXEL, w, chunk);
                                    left = left - chunk;
                                end
                                run_left = '0;
                                run      = RUN_MARKER;
                            end
                            default:
                            begin
                                add_result(bmrld_pkg::KIND_PIXEL, {24'd0, b}, 3'd1);
                                run_left = run_left - 8'd1;
                                if (run_left == 0)
                                    run = RUN_MARKER;
                            end
                        endcase
                    end
                    advance();
                end
            endcase

            if (parse == PARSE_SKIP && pos >= data_start)
                parse = PARSE_DATA;
            // a run in flight holds the record open past its length
            if ((parse == PARSE_DATA && run == RUN_MARKER && pos >= rec_len) ||
                (parse == PARSE_DISCARD && pos >= rec_len))
            begin
                add_result(bmrld_pkg::KIND_END, '0, '0);
                clear_record();
            end
            if (due.size() > n_start)
                due[due.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            fails++;
            $display("mismatch %0d at %0t: %s", fails, $time, msg);
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(pix_result_t got);
            pix_result_t want;
            if (due.size() == 0)
            begin
                report($sformatf("result of kind %0d with nothing pending", got.kind));
                return;
            end
            want = due.pop_front();
            compare("kind", got.kind, want.kind);
            compare("columns", got.columns, want.columns);
            compare("rows", got.rows, want.rows);
            compare("pix_width", got.pix_width, want.pix_width);
            compare("pix_height", got.pix_height, want.pix_height);
            compare("pixels", got.pixels, want.pixels);
            compare("pixel_count", got.pixel_count, want.pixel_count);
            compare("status", got.status, want.status);
            compare("last", got.last, want.last);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [31:0] columns;
    logic [31:0] rows;
    logic [31:0] pix_width;
    logic [31:0] pix_height;
    logic [31:0] pixels;
    logic [2:0]  pixel_count;
    logic [2:0]  status;
    logic        last;

    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    logic        stall_out = 1'b0;
    logic        hold_trigger = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned phase_bytes;
    int unsigned records;
    logic [31:0] mode_now;
    logic [7:0]  rec_bytes [$];
    record_scoreboard sb;

    bitmap_run_length_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .columns     (columns),
        .rows        (rows),
        .pix_width   (pix_width),
        .pix_height  (pix_height),
        .pixels      (pixels),
        .pixel_count (pixel_count),
        .status      (status),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= !stall_out && ($urandom_range(99) >= recv_gap);

    // long output hold-off early in the last phase: the decoder fills and stalls input
    initial
    begin
        wait (hold_trigger);
        repeat (30) @(posedge clk);
        stall_out <= 1'b1;
        repeat (300) @(posedge clk);
        stall_out <= 1'b0;
    end

    // check drained results before predicting from a byte taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.mode_reg = cfg_wr_data;
            if (out_valid && out_ready)
                sb.check_result(pix_result_t'{kind: kind, columns: columns, rows: rows,
                                               pix_width: pix_width, pix_height: pix_height,
                                               pixels: pixels, pixel_count: pixel_count,
                                               status: status, last: last});
            if (in_valid && in_ready)
                sb.note_byte(in_byte);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        phase_bytes++;
    endtask

    task automatic send_record();
        foreach (rec_bytes[i])
            send_byte(rec_bytes[i]);
        rec_bytes.delete();
        records++;
    endtask

    task automatic push_word(input logic [31:0] w);
        rec_bytes = {rec_bytes, w[7:0], w[15:8], w[23:16], w[31:24]};
    endtask

    task automatic push_header(input logic [31:0] len, off, cols, nrows, wid, hgt,
                               input logic [31:0] mode, r0, r1, enc);
        push_word(len);
        push_word(off);
        push_word(cols);
        push_word(nrows);
        push_word(wid);
        push_word(hgt);
        push_word(mode);
        push_word(r0);
        push_word(r1);
        push_word(enc);
    endtask

    // hold until every result is in and the sequencer has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mode(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now     = v;
    endtask

    task automatic directed_records();
        // runs of every size class, a full 32-word repeat, and a literal run past length
        push_header(32'd52, bmrld_pkg::HDR_LEN, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678,
                    32'h8000_0000, mode_now, '0, '0, bmrld_pkg::ENC_CODE_RLE);
        rec_bytes = {rec_bytes, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h02, 8'hA5, 8'h04, 8'h5A,
                     8'hFF, 8'h3C, 8'hFE, 8'h01, 8'h80};
        send_record();
        // raw data, mode, reserved and offset flags raised: bad mode wins
        push_header(32'h2A, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    mode_now ^ 32'h5, 32'hFFFF_FFFF, '0, bmrld_pkg::ENC_CODE_RAW);
        rec_bytes = {rec_bytes, 8'h00, 8'hFF};
        send_record();
        // reserved word set with backward offset
        push_header(32'h29, 32'h27, 32'd1, 32'd2, 32'd3, 32'd4, mode_now, '0, 32'h1,
                    bmrld_pkg::ENC_CODE_RAW);
        rec_bytes = {rec_bytes, 8'hAA};
        send_record();
        // backward offset alone, zero length closes with the descriptor
        push_header(32'h0, 32'h10, 32'd7, 32'd8, 32'd9, 32'd10, mode_now, '0, '0,
                    bmrld_pkg::ENC_CODE_RLE);
        send_record();
        // unknown encoding: drop the rest of the record
        push_header(32'h2C, bmrld_pkg::HDR_LEN, 32'd5, 32'd6, 32'd7, 32'd8, mode_now,
                    '0, '0, 32'hFFFF_FFFF);
        rec_bytes = {rec_bytes, 8'h00, 8'hFF, 8'h55, 8'hAA};
        send_record();
        // offset beyond length: skip to the offset, then close with no data
        push_header(32'h2A, 32'h2D, 32'd11, 32'd12, 32'd13, 32'd14, mode_now, '0, '0,
                    bmrld_pkg::ENC_CODE_RLE);
        rec_bytes = {rec_bytes, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        send_record();
    endtask

    task automatic random_record();
        int unsigned flaw;
        int unsigned n;
        int unsigned i;
        logic [31:0] len;
        logic [31:0] off;
        logic [31:0] mode;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] enc;
        logic [31:0] start;
        logic [31:0] pos;
        logic [7:0]  mk;
        // most records are well formed; one in four carries a single defect
        flaw = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
        mode = (flaw == 1) ? mode_now ^ (32'd1 << $urandom_range(31)) : mode_now;
        r0 = '0;
        r1 = '0;
        if (flaw == 2)
        begin
            if ($urandom_range(1))
                r0 = $urandom() | 32'h1;
            else
                r1 = $urandom() | 32'h8000_0000;
        end
        off = (flaw == 3) ? $urandom_range(bmrld_pkg::HDR_LEN - 1)
                          : bmrld_pkg::HDR_LEN + $urandom_range(4);
        enc = $urandom_range(1) ? bmrld_pkg::ENC_CODE_RLE : bmrld_pkg::ENC_CODE_RAW;
        if (flaw == 4)
        begin
            enc = $urandom();
            if (enc < 2)
                enc = 32'h2;
        end
        start = (off < bmrld_pkg::HDR_LEN) ? bmrld_pkg::HDR_LEN : off;
        len = (flaw == 5) ? $urandom_range(start) : start + $urandom_range(4, 40);
        push_header(len, off, $urandom(), $urandom(), $urandom(), $urandom(), mode, r0, r1, enc);
        pos = bmrld_pkg::HDR_LEN;
        if (enc != bmrld_pkg::ENC_CODE_RAW && enc != bmrld_pkg::ENC_CODE_RLE)
        begin
            while (pos < len)
            begin
                rec_bytes = {rec_bytes, 8'($urandom())};
                pos = pos + 1;
            end
        end
        else
        begin
            while (pos < start)
            begin
                rec_bytes = {rec_bytes, 8'($urandom())};
                pos = pos + 1;
            end
            if (enc == bmrld_pkg::ENC_CODE_RAW)
            begin
                while (pos < len)
                begin
                    rec_bytes = {rec_bytes, 8'($urandom())};
                    pos = pos + 1;
                end
            end
            else
            begin
                // whole runs only; the last may run past the length
                while (pos < len)
                begin
                    if ($urandom_range(1))
                    begin
                        mk = $urandom_range(bmrld_pkg::REP_LIMIT - 1);
                        rec_bytes = {rec_bytes, mk, 8'($urandom())};
                        pos = pos + 2;
                    end
                    else
                    begin
                        mk = ($urandom_range(15) == 0)
                             ? $urandom_range(255, bmrld_pkg::REP_LIMIT)
                             : $urandom_range(255, 240);
                        n = 256 - mk;
                        rec_bytes = {rec_bytes, mk};
                        for (i = 0; i < n; i++)
                            rec_bytes = {rec_bytes, 8'($urandom())};
                        pos = pos + 1 + n;
                    end
                end
            end
        end
        send_record();
    endtask

    initial
    begin
        int unsigned p;
        sb          = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_byte     = '0;
        mode_now    = '0;
        records     = 0;
        phase_bytes = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < 3; p++)
        begin
            send_gap <= (p == 0) ? 21 : (p == 1) ? 59 : 0;
            recv_gap <= (p == 0) ? 59 : (p == 1) ? 21 : 0;
            wait_idle();
            write_mode((p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom());
            if (p == 2)
                hold_trigger <= 1'b1;
            phase_bytes = 0;
            if (p == 0)
                directed_records();
            while (phase_bytes < PHASE_BYTES)
                random_record();
        end
        wait_idle();

        if (sb.due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due.size()));
        $display("covered %0d records, %0d bytes in: %0d descriptors, %0d pixel words, %0d ends",
                 records, sb.bytes_in, sb.descs, sb.words, sb.ends);
        $display("mismatches seen: %0d", sb.fails);
        if (sb.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/bmrld_pkg.sv
hdl/bmrld_ctrl.sv
hdl/bmrld_dpath.sv
hdl/bitmap_run_length_decoder.sv
hdl/bmrld_checker.sv
bench/bitmap_run_length_decoder_test.sv
